/* design/nsq_pkg.sv */
// shared types and constants for the note scale quantizer
package nsq_pkg;

  localparam int unsigned NOTE_W   = 7;
  localparam int unsigned RESULT_W = 8;
  localparam int unsigned MAP_W    = 48;
  localparam int unsigned OP_W     = 2;

  localparam logic [NOTE_W-1:0] TOP_NOTE    = 7'd127;
  localparam logic [NOTE_W-1:0] BOTTOM_NOTE = 7'd0;
  localparam logic [3:0]        SEMITONES   = 4'd12;
  localparam logic [3:0]        NIBBLE_MASK = 4'hF;
  localparam logic [MAP_W-1:0]  MAP_RESET   = 48'hBA9876543210;

  // n / 12 as (n * 43) >> 9, exact for n in 0..127
  localparam logic [5:0] DIV12_MUL   = 6'd43;
  localparam int unsigned DIV12_SHIFT = 9;

  localparam logic [OP_W-1:0] OP_QUANT = 2'd0;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd1;
  localparam logic [OP_W-1:0] OP_PREV  = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD  = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_STEP
  } state_t;

endpackage

/* design/nsq_quant.sv */
// quantize unit: splits a note into octave and pitch class and maps it through the scale
module nsq_quant (
  input  logic [nsq_pkg::MAP_W-1:0]    scale_map,
  input  logic [nsq_pkg::NOTE_W-1:0]   cand,
  output logic [nsq_pkg::RESULT_W-1:0] quant_note
);
  import nsq_pkg::*;

  logic [12:0]         prod;
  logic [3:0]          octave;
  logic [7:0]          oct_base;
  logic [3:0]          pclass;
  logic [MAP_W-1:0]    shifted;
  logic [3:0]          target;

  always_comb begin
    prod     = {7'd0, DIV12_MUL} * {6'd0, cand};
    octave   = prod[DIV12_SHIFT +: 4];
    oct_base = {4'd0, octave} * {4'd0, SEMITONES};
    pclass   = 4'(cand - oct_base[NOTE_W-1:0]);
    shifted  = scale_map >> {pclass, 2'b00};
    target   = shifted[3:0] & NIBBLE_MASK;
    quant_note = oct_base + {4'd0, target};
  end

endmodule

/* design/note_scale_quantizer.sv */
// top level of the note scale quantizer: command port, scale register and walk sequencer
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+-----------------------------
//  input   | start, busy, in_operation, in_note      | start && !busy
//  result  | out_valid, out_result_note              | out_valid, one cycle pulse
//  config  | cfg_we, cfg_wdata                       | cfg_we
//
// quantize latches the command, then makes one pass through the shared quantize
// unit, and the result pulse follows.
// next/prev latch the command, then walk k candidates, where k is the number the walk
// visits (one candidate per cycle through the same unit); at most twelve
// candidates in a row can quantize to the input note, so k is at most 13.
// edge cases and the unused code answer straight from idle, in the next cycle.
// busy is high while the walk runs; the receiver cannot stall, so a result is
// simply shown for one cycle. synchronous reset loads the chromatic scale.
module note_scale_quantizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [nsq_pkg::OP_W-1:0]      in_operation,
  input  logic [nsq_pkg::NOTE_W-1:0]    in_note,
  output logic                          out_valid,
  output logic [nsq_pkg::RESULT_W-1:0]  out_result_note,
  input  logic                          cfg_we,
  input  logic [nsq_pkg::MAP_W-1:0]     cfg_wdata
);
  import nsq_pkg::*;

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [NOTE_W-1:0]   note_r, note_nxt;
  logic [NOTE_W-1:0]   cand_r, cand_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [RESULT_W-1:0] out_note_r, out_note_nxt;
  logic [MAP_W-1:0]    scale_r;
  logic [RESULT_W-1:0] quant_note;
  logic                at_limit;
  logic                step_done;

  // scale register; the host writes it only while idle, a rule on the host that the block does not enforce
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= MAP_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // shared quantize unit, fed by the current candidate
  nsq_quant u_quant (
    .scale_map  (scale_r),
    .cand       (cand_r),
    .quant_note (quant_note)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    note_r     <= note_nxt;
    cand_r     <= cand_nxt;
    out_note_r <= out_note_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    note_nxt      = note_r;
    cand_nxt      = cand_r;
    out_valid_nxt = 1'b0;
    out_note_nxt  = out_note_r;
    // walk ends at the top for next, at the bottom for prev
    at_limit  = (op_r == OP_NEXT) ? (cand_r == TOP_NOTE) : (cand_r == BOTTOM_NOTE);
    step_done = (op_r == OP_QUANT) || (quant_note != {1'b0, note_r}) || at_limit;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt   = in_operation;
          note_nxt = in_note;
          unique case (in_operation)
            OP_QUANT: begin
              cand_nxt  = in_note;
              state_nxt = ST_STEP;
            end
            OP_NEXT: begin
              if (in_note == TOP_NOTE) begin
                // already at the top, note comes back unchanged
                out_valid_nxt = 1'b1;
                out_note_nxt  = {1'b0, in_note};
              end else begin
                cand_nxt  = in_note + 7'd1;
                state_nxt = ST_STEP;
              end
            end
            OP_PREV: begin
              if (in_note == BOTTOM_NOTE) begin
                // already at the bottom, note comes back unchanged
                out_valid_nxt = 1'b1;
                out_note_nxt  = {1'b0, in_note};
              end else begin
                cand_nxt  = in_note - 7'd1;
                state_nxt = ST_STEP;
              end
            end
            default: begin
              // unused code passes the note through
              out_valid_nxt = 1'b1;
              out_note_nxt  = {1'b0, in_note};
            end
          endcase
        end
      end
      ST_STEP: begin
        if (step_done) begin
          out_valid_nxt = 1'b1;
          out_note_nxt  = quant_note;
          state_nxt     = ST_IDLE;
        end else if (op_r == OP_NEXT) begin
          cand_nxt = cand_r + 7'd1;
        end else begin
          cand_nxt = cand_r - 7'd1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_note = out_note_r;

endmodule

/* design/nsq_checker.sv */
// port-level checker for the note scale quantizer and its bind
module nsq_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic [nsq_pkg::OP_W-1:0]      in_operation,
  input  logic [nsq_pkg::NOTE_W-1:0]    in_note,
  input  logic                          out_valid,
  input  logic [nsq_pkg::RESULT_W-1:0]  out_result_note
);
  import nsq_pkg::*;

  // a result pulse always lands with the block back at idle
  a_valid_idle: assert property (@(posedge clk) out_valid |-> !busy)
    else $error("result strobe while busy");

  // a quantize command always enters the walk
  a_quant_busy: assert property (@(posedge clk)
    rst_n && start && !busy && (in_operation == OP_QUANT) |=> busy && !out_valid)
    else $error("quantize command did not start the unit");

  // unused code answers next cycle with the note itself
  a_rsvd_pass: assert property (@(posedge clk)
    rst_n && start && !busy && (in_operation == OP_RSVD) |=>
      out_valid && (out_result_note == {1'b0, $past(in_note)}))
    else $error("unused code did not pass the note through");

  // busy only drops when a result goes out
  a_done_pulse: assert property (@(posedge clk)
    $fell(busy) && $past(rst_n) |-> out_valid)
    else $error("walk ended without a result");

endmodule

bind note_scale_quantizer nsq_checker u_nsq_checker (.*);
